// File: src/ewr_pkg.sv
// Package with shared constants, types and helpers of the echo pulse width ranger.
`default_nettype none

package ewr_pkg;

  // Default width of the overflow counter.
  localparam int unsigned EwrOvfBits = 6;

  // Width of the configuration index and data fields.
  localparam int unsigned EwrCfgIdxW  = 8;
  localparam int unsigned EwrCfgDataW = 8;

  // Configuration register indexes.
  localparam logic [EwrCfgIdxW-1:0] EWR_REG_OFFSET = 8'd0;
  localparam logic [EwrCfgIdxW-1:0] EWR_REG_BAND   = 8'd1;

  // Reset values of the configuration registers.
  localparam logic [EwrCfgDataW-1:0] EWR_OFFSET_RST = 8'd20;
  localparam logic [EwrCfgDataW-1:0] EWR_BAND_RST   = 8'd6;

  // Request kinds.
  localparam logic EWR_KIND_TIMER = 1'b0;
  localparam logic EWR_KIND_READ  = 1'b1;

  // Divisor of the millimetre conversion; the multiplier is 170 = 17 * 10.
  localparam int unsigned EwrDivisor = 1000;

  // Number of radix-16 quotient digits for a product of (32 + ovf_bits + 8) bits.
  function automatic int unsigned ewr_ndig(int unsigned ovf_bits);
    return (ovf_bits + 32 + 8 + 3) / 4;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ev_apply;    // apply a timer event to the capture state
    logic rd_zero;     // answer a read with nothing ready
    logic load_total;  // form overflows * 0xFFFFFFFF + count
    logic mul17;       // total * 17
    logic mul10;       // * 10, load the divider
    logic div_step;    // one radix-16 division step
    logic add_off;     // add offset and saturate
    logic diff;        // distance to the last reading and their sum
    logic smooth;      // pick the smoothed value and re-arm the capture
    logic load_out;    // move the result into the output register
  } ewr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pulse_done;
    logic out_free;
  } ewr_status_t;

endpackage

`default_nettype wire

// File: src/ewr_ctrl.sv
// Controller state machine that sequences timer events and distance reads.
`default_nettype none

module ewr_ctrl #(
  parameter int unsigned OVERFLOW_BITS = ewr_pkg::EwrOvfBits
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_fire_i,
  input  wire                  s_kind_i,
  input  ewr_pkg::ewr_status_t status_i,
  output ewr_pkg::ewr_cmd_t    cmd_o,
  output logic                 s_ready_o
);
  import ewr_pkg::*;

  localparam int unsigned NDig = ewr_ndig(OVERFLOW_BITS);
  localparam int unsigned CntW = $clog2(NDig);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MUL17   = 4'd1;
  localparam logic [3:0] ST_MUL10   = 4'd2;
  localparam logic [3:0] ST_DIV     = 4'd3;
  localparam logic [3:0] ST_OFFSET  = 4'd4;
  localparam logic [3:0] ST_DIFF    = 4'd5;
  localparam logic [3:0] ST_SMOOTH  = 4'd6;
  localparam logic [3:0] ST_DELIVER = 4'd7;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] dig_q, dig_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    cmd_o   = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_fire_i) begin
          if (s_kind_i == EWR_KIND_TIMER) begin
            cmd_o.ev_apply = 1'b1;
          end else if (status_i.pulse_done) begin
            cmd_o.load_total = 1'b1;
            state_d = ST_MUL17;
          end else begin
            cmd_o.rd_zero = 1'b1;
            state_d = ST_DELIVER;
          end
        end
      end
      ST_MUL17: begin
        cmd_o.mul17 = 1'b1;
        state_d = ST_MUL10;
      end
      ST_MUL10: begin
        cmd_o.mul10 = 1'b1;
        dig_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (dig_q == CntW'(NDig - 1)) begin
          state_d = ST_OFFSET;
        end else begin
          dig_d = dig_q + 1'b1;
        end
      end
      ST_OFFSET: begin
        cmd_o.add_off = 1'b1;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dig_q   <= '0;
    end else begin
      state_q <= state_d;
      dig_q   <= dig_d;
    end
  end

endmodule

`default_nettype wire

// File: src/ewr_dp.sv
// Datapath with capture state, conversion arithmetic, divider and output register.
`default_nettype none

module ewr_dp #(
  parameter int unsigned OVERFLOW_BITS = ewr_pkg::EwrOvfBits
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  ewr_pkg::ewr_cmd_t                    cmd_i,
  output ewr_pkg::ewr_status_t                 status_o,
  input  wire                                  ev_ovf_i,
  input  wire                                  ev_cap_i,
  input  wire  [31:0]                          ev_count_i,
  input  wire                                  cfg_we_i,
  input  wire  [ewr_pkg::EwrCfgIdxW-1:0]       cfg_index_i,
  input  wire  [ewr_pkg::EwrCfgDataW-1:0]      cfg_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [31:0]                          out_dist_o,
  output logic                                 out_rdy_o
);
  import ewr_pkg::*;

  localparam int unsigned TotW = 32 + OVERFLOW_BITS;
  localparam int unsigned P17W = TotW + 5;
  localparam int unsigned ProdW = TotW + 8;
  localparam int unsigned NDig = ewr_ndig(OVERFLOW_BITS);
  localparam int unsigned DivW = NDig * 4;
  localparam int unsigned RemW = 10;
  localparam int unsigned StepW = RemW + 4;

  // Configuration registers.
  logic [EwrCfgDataW-1:0] offset_q, band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= EWR_OFFSET_RST;
      band_q   <= EWR_BAND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        EWR_REG_OFFSET: offset_q <= cfg_data_i;
        EWR_REG_BAND:   band_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture state.
  logic                     done_q, done_d;
  logic                     start_q, start_d;
  logic [OVERFLOW_BITS-1:0] ovfc_q, ovfc_d;
  logic [31:0]              pcnt_q, pcnt_d;
  logic [31:0]              last_q, last_d;
  logic [31:0]              final_dist;

  always_comb begin
    done_d  = done_q;
    start_d = start_q;
    ovfc_d  = ovfc_q;
    pcnt_d  = pcnt_q;
    last_d  = last_q;
    if (cmd_i.ev_apply && !done_q) begin
      // An overflow is handled before a capture of the same event.
      if (ev_ovf_i && start_q) begin
        if (&ovfc_q) begin
          done_d = 1'b1;
          pcnt_d = '1;
        end else begin
          ovfc_d = ovfc_q + 1'b1;
        end
      end
      if (ev_cap_i) begin
        if (start_q) begin
          done_d = 1'b1;
          pcnt_d = ev_count_i;
        end else begin
          ovfc_d  = '0;
          pcnt_d  = '0;
          start_d = 1'b1;
        end
      end
    end
    if (cmd_i.smooth) begin
      // Commit the reading and re-arm the capture; the count is kept.
      last_d  = final_dist;
      done_d  = 1'b0;
      start_d = 1'b0;
      ovfc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      start_q <= 1'b0;
      ovfc_q  <= '0;
      pcnt_q  <= '0;
      last_q  <= '0;
    end else begin
      done_q  <= done_d;
      start_q <= start_d;
      ovfc_q  <= ovfc_d;
      pcnt_q  <= pcnt_d;
      last_q  <= last_d;
    end
  end

  // Conversion: total * 17, then * 10, then radix-16 division by the divisor.
  logic [TotW-1:0]  total_q;
  logic [P17W-1:0]  p17_q;
  logic [ProdW-1:0] prod;
  logic [DivW-1:0]  div_q;
  logic [RemW-1:0]  rem_q;
  logic [StepW-1:0] step_r;
  logic [3:0]       digit;
  logic [DivW:0]    off_sum;
  logic [31:0]      dist_q;
  logic [31:0]      absdiff_q;
  logic [32:0]      pair_sum_q;
  logic [31:0]      res_dist_q;
  logic             res_rdy_q;

  assign prod = (ProdW'(p17_q) << 3) + (ProdW'(p17_q) << 1);
  assign step_r = {rem_q, div_q[DivW-1 -: 4]};

  // Quotient digit: the largest k with k * divisor not above the partial remainder.
  always_comb begin
    digit = '0;
    for (int k = 1; k < 16; k++) begin
      if (step_r >= StepW'(k * EwrDivisor)) begin
        digit = 4'(k);
      end
    end
  end

  assign off_sum = (DivW+1)'(div_q) + (DivW+1)'(offset_q);
  assign final_dist = (absdiff_q < 32'(band_q)) ? pair_sum_q[32:1] : dist_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_total) begin
      total_q <= TotW'({ovfc_q, 32'h0}) - TotW'(ovfc_q) + TotW'(pcnt_q);
    end
    if (cmd_i.mul17) begin
      p17_q <= (P17W'(total_q) << 4) + P17W'(total_q);
    end
    if (cmd_i.mul10) begin
      div_q <= DivW'(prod);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      div_q <= {div_q[DivW-5:0], digit};
      rem_q <= RemW'(step_r - StepW'(digit * EwrDivisor));
    end
    if (cmd_i.add_off) begin
      // Saturate to 32 bits.
      dist_q <= (|off_sum[DivW:32]) ? '1 : off_sum[31:0];
    end
    if (cmd_i.diff) begin
      absdiff_q  <= (last_q >= dist_q) ? (last_q - dist_q) : (dist_q - last_q);
      pair_sum_q <= {1'b0, last_q} + {1'b0, dist_q};
    end
    if (cmd_i.smooth) begin
      res_dist_q <= final_dist;
      res_rdy_q  <= 1'b1;
    end else if (cmd_i.rd_zero) begin
      res_dist_q <= '0;
      res_rdy_q  <= 1'b0;
    end
  end

  // Output register.
  logic        out_valid_q;
  logic [31:0] out_dist_q;
  logic        out_rdy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_dist_q <= res_dist_q;
      out_rdy_q  <= res_rdy_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dist_o  = out_dist_q;
  assign out_rdy_o   = out_rdy_q;

  assign status_o.pulse_done = done_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// File: src/echo_pulse_width_ranger_top.sv
// Top level of the echo pulse width ranger: stream ports, controller and datapath.
`default_nettype none

// Measures an ultrasonic echo pulse by input capture. Timer event requests
// (tuser 0) update the capture state in the cycle they are accepted. A read
// request (tuser 1) returns one result: with no completed pulse it returns
// distance 0 with tuser 0; with a completed pulse it multiplies by 17 and
// by 10, the radix-16 divider divides by 1000 one digit per cycle, and it
// returns the smoothed distance in millimetres with tuser 1.
// The block accepts one request at a time; a timer event is taken while a
// result waits in the output register.
module echo_pulse_width_ranger_top #(
  parameter int unsigned OVERFLOW_BITS = ewr_pkg::EwrOvfBits
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Request stream.
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: [0] overflow_flag, [1] capture_flag, [33:2] capture_count, [39:34] zero
  input  wire  [39:0]                     s_axis_tdata,
  // tuser: [0] kind
  input  wire                             s_axis_tuser,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // tdata: [31:0] distance_mm
  output logic [31:0]                     m_axis_tdata,
  // tuser: [0] ready_res
  output logic                            m_axis_tuser,
  // Configuration write channel.
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [ewr_pkg::EwrCfgIdxW-1:0]  cfg_index_i,
  input  wire  [ewr_pkg::EwrCfgDataW-1:0] cfg_data_i
);
  import ewr_pkg::*;

  ewr_cmd_t    cmd;
  ewr_status_t status;
  logic        s_fire;

  assign s_fire      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  ewr_ctrl #(
    .OVERFLOW_BITS(OVERFLOW_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_fire_i (s_fire),
    .s_kind_i (s_axis_tuser),
    .status_i (status),
    .cmd_o    (cmd),
    .s_ready_o(s_axis_tready)
  );

  ewr_dp #(
    .OVERFLOW_BITS(OVERFLOW_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .ev_ovf_i   (s_axis_tdata[0]),
    .ev_cap_i   (s_axis_tdata[1]),
    .ev_count_i (s_axis_tdata[33:2]),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_dist_o (m_axis_tdata),
    .out_rdy_o  (m_axis_tuser)
  );

  // A result that carries no converted pulse reads as distance zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'h0))
    else $error("nothing-ready result with nonzero distance");

  // A read request holds off the next request in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (s_axis_tuser == EWR_KIND_READ)) |=> !s_axis_tready)
    else $error("request accepted while a read is in progress");

  // A timer event never stalls the request stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (s_axis_tuser == EWR_KIND_TIMER)) |=> s_axis_tready)
    else $error("timer event stalled the request stream");

endmodule

`default_nettype wire
